@@ rtl/ppc_pkg.sv @@
// Package for the pixel predictor codec.
// Holds mode codes, the request item type and the median clamp function.
// No dependencies.
`default_nettype none

package ppc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;

    localparam logic [MODE_W-1:0] MODE_HDIFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HACC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MED   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PASS  = 2'd3;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        sample_t above;
        logic    first_in_row;
    } ppc_item_t;

    // left + above - above_left, clamped to [min(left, above), max(left, above)]
    function automatic sample_t med_guess(input sample_t a, input sample_t b,
                                          input sample_t c);
        sample_t g;
        sample_t lo;
        sample_t hi;
        g  = a + b - c;
        lo = (a < b) ? a : b;
        hi = (a > b) ? a : b;
        if (g < lo)
        begin
            med_guess = lo;
        end
        else if (g > hi)
        begin
            med_guess = hi;
        end
        else
        begin
            med_guess = g;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/pixel_predictor_codec.sv @@
// Pixel predictor codec: horizontal diff/accumulate, median predictor and pass-through.
// Path: input reg, then result reg. Left/above-left feedback is one add per cycle.
// Throughput: one request per cycle unless out_ready stalls the output.
// Reset: rst_n async low clears mode, left and above-left state and both valid flags.
// Depends on ppc_pkg and ppc_predict.
`default_nettype none

module pixel_predictor_codec
    import ppc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [MODE_W-1:0]   cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [SAMPLE_W-1:0] above,
    input  wire logic                first_in_row,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      value
);

    logic [MODE_W-1:0] mode_reg;
    logic              s1_valid_reg;
    ppc_item_t         s1_item_reg;
    logic              out_valid_reg;
    sample_t           value_reg;
    sample_t           left_value_reg;
    sample_t           above_left_reg;

    sample_t           value_next;
    sample_t           left_next;
    logic              s1_advance;
    logic              in_accept;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign value      = value_reg;

    ppc_predict u_predict
    (
        .mode       (mode_reg),
        .item       (s1_item_reg),
        .left_value (left_value_reg),
        .above_left (above_left_reg),
        .value      (value_next),
        .left_next  (left_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HDIFF;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_value_reg <= '0;
            above_left_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg  <= 1'b1;
                left_value_reg <= left_next;
                above_left_reg <= s1_item_reg.above;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.sample       <= sample;
            s1_item_reg.above        <= above;
            s1_item_reg.first_in_row <= first_in_row;
        end
        if (s1_advance)
        begin
            value_reg <= value_next;
        end
    end

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request lost from input stage");

    a_above_left: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> above_left_reg == $past(s1_item_reg.above))
        else $error("above_left not updated from advanced request");

    a_hdiff_left: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && mode_reg == MODE_HDIFF) |=>
            left_value_reg == $past(s1_item_reg.sample))
        else $error("left value not raw sample in horizontal difference");

endmodule

`default_nettype wire

@@ rtl/ppc_predict.sv @@
// Prediction datapath: result value and next left value for one request.
// Depends on ppc_pkg.
`default_nettype none

module ppc_predict
    import ppc_pkg::*;
(
    input  wire logic [MODE_W-1:0] mode,
    input  wire ppc_item_t         item,
    input  wire sample_t           left_value,
    input  wire sample_t           above_left,
    output sample_t                value,
    output sample_t                left_next
);

    sample_t guess;

    assign guess = med_guess(left_value, item.above, above_left);

    always_comb
    begin
        unique case (mode)
            MODE_HDIFF:
            begin
                value     = item.first_in_row ? item.sample : item.sample - left_value;
                left_next = item.sample;
            end
            MODE_HACC:
            begin
                value     = item.first_in_row ? item.sample : item.sample + left_value;
                left_next = value;
            end
            MODE_MED:
            begin
                value     = item.first_in_row ? item.sample - item.above
                                              : item.sample - guess;
                left_next = item.sample;
            end
            MODE_PASS:
            begin
                value     = item.sample;
                left_next = item.sample;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/tb_pixel_predictor_codec.sv @@
// Testbench for pixel_predictor_codec: directed table, then random rows across all modes.
// Checked against directed wants or an in-bench predictor under random idling and stalls.
// Depends on ppc_pkg and the pixel_predictor_codec RTL.
`timescale 1ns / 1ps

module tb_pixel_predictor_codec;
    import ppc_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 55;
    localparam int HOLD_CYCLES  = 60;
    localparam int DIR_ROWS     = 19;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        sample_t           sample;
        sample_t           above;
        logic              first;
        logic              chk;
        sample_t           want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_ready;
    sample_t           sample;
    sample_t           above;
    logic              first_in_row;
    logic              out_valid;
    logic              out_ready;
    sample_t           value;

    logic [MODE_W-1:0] mode_q;
    sample_t           left_q;
    sample_t           above_left_q;
    sample_t           pending_values[$];
    sample_t           got_want;
    dir_row_t          dir_rows [0:DIR_ROWS-1];
    int                mismatches;
    int                cycles;
    int                send_idle;
    int                recv_idle;
    int                hold_asks;

    pixel_predictor_codec uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .above        (above),
        .first_in_row (first_in_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic sample_t predict_value(input sample_t s, input sample_t a, input logic f);
        sample_t v;
        sample_t g;
        sample_t lo;
        sample_t hi;
        case (mode_q)
            MODE_HDIFF:
            begin
                v      = f ? s : sample_t'(s - left_q);
                left_q = s;
            end
            MODE_HACC:
            begin
                v      = f ? s : sample_t'(s + left_q);
                left_q = v;
            end
            MODE_MED:
            begin
                g  = left_q + a - above_left_q;
                lo = (left_q < a) ? left_q : a;
                hi = (left_q > a) ? left_q : a;
                if (g < lo)
                begin
                    g = lo;
                end
                else if (g > hi)
                begin
                    g = hi;
                end
                v      = f ? sample_t'(s - a) : sample_t'(s - g);
                left_q = s;
            end
            default:
            begin
                v      = s;
                left_q = s;
            end
        endcase
        above_left_q = a;
        return v;
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // called just after a rising edge; returns at the edge that accepts the request
    task automatic send_item(input sample_t s, input sample_t a, input logic f,
                             input logic chk, input sample_t typed);
        sample_t pred;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= s;
        above        <= a;
        first_in_row <= f;
        do
            @(posedge clk);
        while (!in_ready);
        pred = predict_value(s, a, f);
        pending_values.push_back(chk ? typed : pred);
    endtask

    task automatic wait_idle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_q = m;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected value, expected none, actual %h", $time, value);
                mismatches++;
            end
            else
            begin
                got_want = pending_values.pop_front();
                if (value !== got_want)
                begin
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, got_want, value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_pixel_predictor_codec: done, errors");
            $finish;
        end
    end

    initial
    begin
        int               i;
        int               p;
        int               n;
        int               row_left;
        logic             f;
        logic [MODE_W-1:0] pm;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = MODE_HDIFF;
        in_valid     = 1'b0;
        sample       = '0;
        above        = '0;
        first_in_row = 1'b0;
        mode_q       = MODE_HDIFF;
        left_q       = '0;
        above_left_q = '0;
        mismatches   = 0;
        cycles       = 0;
        send_idle    = 0;
        recv_idle    = 0;
        hold_asks    = 0;

        dir_rows[0]  = '{MODE_HDIFF, 16'h1234, 16'h0000, 1'b0, 1'b1, 16'h1234};
        dir_rows[1]  = '{MODE_HDIFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF};
        dir_rows[2]  = '{MODE_HDIFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0001};
        dir_rows[3]  = '{MODE_HDIFF, 16'h8000, 16'hAAAA, 1'b0, 1'b0, 16'h0000};
        dir_rows[4]  = '{MODE_HDIFF, 16'h7FFF, 16'h5555, 1'b0, 1'b0, 16'h0000};
        dir_rows[5]  = '{MODE_HACC,  16'h0001, 16'h0000, 1'b0, 1'b0, 16'h0000};
        dir_rows[6]  = '{MODE_HACC,  16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF};
        dir_rows[7]  = '{MODE_HACC,  16'h0001, 16'h0000, 1'b0, 1'b1, 16'h0000};
        dir_rows[8]  = '{MODE_HACC,  16'h8000, 16'hFFFF, 1'b0, 1'b0, 16'h0000};
        dir_rows[9]  = '{MODE_MED,   16'h1000, 16'h2000, 1'b1, 1'b1, 16'hF000};
        dir_rows[10] = '{MODE_MED,   16'h0500, 16'h3000, 1'b0, 1'b0, 16'h0000};
        dir_rows[11] = '{MODE_MED,   16'hFFFF, 16'h0100, 1'b0, 1'b0, 16'h0000};
        dir_rows[12] = '{MODE_MED,   16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'h0000};
        dir_rows[13] = '{MODE_MED,   16'h4000, 16'h4000, 1'b0, 1'b0, 16'h0000};
        dir_rows[14] = '{MODE_PASS,  16'hABCD, 16'h1234, 1'b0, 1'b1, 16'hABCD};
        dir_rows[15] = '{MODE_PASS,  16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000};
        dir_rows[16] = '{MODE_MED,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000};
        dir_rows[17] = '{MODE_HDIFF, 16'h5A5A, 16'h0000, 1'b1, 1'b1, 16'h5A5A};
        dir_rows[18] = '{MODE_HDIFF, 16'hA5A5, 16'hFFFF, 1'b0, 1'b0, 16'h0000};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].mode != mode_q)
            begin
                wait_idle(DRAIN_CYCLES);
                write_mode(dir_rows[i].mode);
            end
            send_item(dir_rows[i].sample, dir_rows[i].above, dir_rows[i].first,
                      dir_rows[i].chk, dir_rows[i].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       pm = MODE_HDIFF;
                1:       pm = MODE_HACC;
                2:       pm = MODE_MED;
                default: pm = MODE_PASS;
            endcase
            if (pm != mode_q)
            begin
                wait_idle(DRAIN_CYCLES);
                write_mode(pm);
            end
            case ((p / 2) % 4)
                0:       begin send_idle = 0;  recv_idle = 0;  end
                1:       begin send_idle = 52; recv_idle = 0;  end
                2:       begin send_idle = 0;  recv_idle = 52; end
                default: begin send_idle = 21; recv_idle = 21; end
            endcase
            // long receiver hold-off so the block backs up into its input
            if (p == 4 || p == 8)
            begin
                hold_asks++;
            end
            row_left = 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && (p == 2 || p == 9))
                begin
                    wait_idle(0);
                end
                if (row_left == 0)
                begin
                    f        = 1'b1;
                    row_left = $urandom_range(16, 1);
                end
                else
                begin
                    f = 1'b0;
                end
                row_left--;
                if ($urandom_range(15) == 0)
                begin
                    f = ~f;
                end
                send_item(pick_sample(), pick_sample(), f, 1'b0, '0);
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (mismatches == 0)
        begin
            $display("tb_pixel_predictor_codec: done, clean");
        end
        else
        begin
            $display("tb_pixel_predictor_codec: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ppc_pkg.sv
rtl/ppc_predict.sv
rtl/pixel_predictor_codec.sv
tb/tb_pixel_predictor_codec.sv
